// ===== src/lpc_pkg.sv =====
`default_nettype none
package lpc_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_WRITE,
		ST_EMIT
	} lpc_state_t;

	typedef enum logic [2:0] {
		REG_DIRECTION    = 3'd0,
		REG_WIDTH_CODE   = 3'd1,
		REG_DIM_COUNT    = 3'd2,
		REG_EXTENT_INNER = 3'd3,
		REG_EXTENT_2ND   = 3'd4,
		REG_EXTENT_3RD   = 3'd5,
		REG_VALUE_COUNT  = 3'd6
	} lpc_reg_t;

	localparam int unsigned SAMPLE_W = 64;
	localparam int unsigned INDEX_W  = 48;
	localparam int unsigned EXTENT_W = 15;

	// controller -> datapath
	typedef struct packed {
		logic       load;     // capture input sample
		logic       clear;    // start accumulation
		logic       rd_en;    // issue history read for corner
		logic [3:0] corner;   // corner being issued
		logic       acc_en;   // accumulate registered read data
		logic       acc_par;  // parity of the corner whose data returns
		logic       wr_en;    // write history, advance index
		logic       out_load; // load output register
	} lpc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] dims;
		logic       dir;
	} lpc_status_t;

	function automatic logic parity4(input logic [3:0] v);
		return ^v;
	endfunction

endpackage
`default_nettype wire

// ===== src/lpc_ram.sv =====
`default_nettype none
module lpc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/lpc_ctrl.sv =====
`default_nettype none
module lpc_ctrl
	import lpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire lpc_status_t status,
	output lpc_cmd_t         cmd
);
	lpc_state_t state_q, state_d;
	logic [4:0] cnt_q, cnt_d;     // corner counter, one past the last at 2^d
	logic       pend_q, pend_d;   // read in flight
	logic       ppar_q, ppar_d;
	logic       ovalid_q, ovalid_d;
	logic [4:0] ncorn;

	assign ncorn = 5'd1 << status.dims;
	// a waiting result sits in the output register; the next sample may still start
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
			ppar_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			pend_q   <= pend_d;
			ppar_q   <= ppar_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pend_d   = 1'b0;
		ppar_d   = ppar_q;
		ovalid_d = ovalid_q && !out_ready;
		cmd      = '0;
		cmd.corner  = cnt_q[3:0];
		cmd.acc_en  = pend_q;
		cmd.acc_par = ppar_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load  = 1'b1;
					cmd.clear = 1'b1;
					state_d   = ST_ISSUE;
					cnt_d     = '0;
				end
			end
			ST_ISSUE: begin
				// forward starts at corner 0, reverse at corner 1
				if (cnt_q == 5'd0 && status.dir) begin
					cnt_d = 5'd1;
				end else if (cnt_q >= ncorn) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.rd_en = 1'b1;
					pend_d    = 1'b1;
					ppar_d    = parity4(cnt_q[3:0]);
					cnt_d     = cnt_q + 5'd1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!ovalid_q || out_ready) begin
					cmd.out_load = 1'b1;
					ovalid_d     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	ast_one_corner_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> cmd.acc_en)
		else $error("read data not accumulated");
	ast_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("sample loaded while busy");
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
endmodule
`default_nettype wire

// ===== src/lpc_dp.sv =====
`default_nettype none
module lpc_dp
	import lpc_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 16384,
	parameter int unsigned MAX_DIMS     = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_idx,
	input  wire logic [INDEX_W-1:0]  cfg_data,
	input  wire logic [SAMPLE_W-1:0] sample_in,
	input  wire lpc_cmd_t            cmd,
	output lpc_status_t              status,
	output logic [SAMPLE_W-1:0]      sample_out,
	output logic                     block_last,
	output logic                     config_error
);
	localparam int unsigned AW = $clog2(WINDOW_DEPTH);
	localparam int unsigned SW = 48; // strides fit in 3*15 bits

	logic                dir_q;
	logic [1:0]          wc_q;
	logic [2:0]          dc_q;
	logic [EXTENT_W-1:0] ext_q [3];
	logic [INDEX_W-1:0]  vc_q;
	logic [INDEX_W-1:0]  idx_q;

	logic [SAMPLE_W-1:0] x_q, acc_q, rdata, mask, accm;
	logic [SW-1:0]       st1_q, st2_q, st3_q, off, largest;
	logic [2:0]          dims;
	logic                hit;
	logic [INDEX_W-1:0]  vc1, nidx;

	function automatic logic [EXTENT_W-1:0] al1(input logic [EXTENT_W-1:0] v);
		return (v == '0) ? EXTENT_W'(1) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= 1'b0;
			wc_q   <= '0;
			dc_q   <= 3'd1;
			ext_q  <= '{default: EXTENT_W'(1)};
			vc_q   <= INDEX_W'(1);
			idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_DIRECTION:    dir_q    <= cfg_data[0];
					REG_WIDTH_CODE:   wc_q     <= cfg_data[1:0];
					REG_DIM_COUNT:    dc_q     <= cfg_data[2:0];
					REG_EXTENT_INNER: ext_q[0] <= cfg_data[EXTENT_W-1:0];
					REG_EXTENT_2ND:   ext_q[1] <= cfg_data[EXTENT_W-1:0];
					REG_EXTENT_3RD:   ext_q[2] <= cfg_data[EXTENT_W-1:0];
					REG_VALUE_COUNT:  vc_q     <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.wr_en) begin
				idx_q <= nidx;
			end
		end
	end

	// strides settle through st2_q into st3_q after a config write; the earliest
	// corner that uses the inner*second*third stride is issued well after that
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st1_q <= SW'(1);
			st2_q <= SW'(1);
			st3_q <= SW'(1);
		end else begin
			st1_q <= SW'(al1(ext_q[0]));
			st2_q <= SW'({15'd0, al1(ext_q[0])} * {15'd0, al1(ext_q[1])});
			st3_q <= SW'({15'd0, st2_q[29:0]} * {30'd0, al1(ext_q[2])});
		end
	end

	assign dims = (dc_q > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : dc_q;
	assign status.dims = dims;
	assign status.dir  = dir_q;

	always_comb begin
		off = '0;
		if (cmd.corner[0] && dims > 3'd0) off = off + SW'(1);
		if (cmd.corner[1] && dims > 3'd1) off = off + st1_q;
		if (cmd.corner[2] && dims > 3'd2) off = off + st2_q;
		if (cmd.corner[3] && dims > 3'd3) off = off + st3_q;
		largest = '0;
		if (dims > 3'd0) largest = largest + SW'(1);
		if (dims > 3'd1) largest = largest + st1_q;
		if (dims > 3'd2) largest = largest + st2_q;
		if (dims > 3'd3) largest = largest + st3_q;
	end

	assign hit = (off <= idx_q) && (off < SW'(WINDOW_DEPTH)) && (off != '0);

	always_comb begin
		case (wc_q)
			2'd0:    mask = 64'h0000_0000_0000_00FF;
			2'd1:    mask = 64'h0000_0000_0000_FFFF;
			2'd2:    mask = 64'h0000_0000_FFFF_FFFF;
			default: mask = '1;
		endcase
	end

	logic [SAMPLE_W-1:0] x_in;
	assign x_in = sample_in & mask;

	// data for a corner: zero offset uses the sample, missed corners add nothing
	logic                zero_s1, hit_s1;
	logic [SAMPLE_W-1:0] h;
	always_ff @(posedge clk) begin
		zero_s1 <= (off == '0);
		hit_s1  <= hit;
	end
	assign h = zero_s1 ? x_q : (hit_s1 ? rdata : '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x_in;
		end
		if (cmd.clear) begin
			acc_q <= dir_q ? x_in : '0;
		end else if (cmd.acc_en) begin
			if (cmd.acc_par ^ dir_q) acc_q <= acc_q - h;
			else                     acc_q <= acc_q + h;
		end
	end

	assign accm = acc_q & mask;

	lpc_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_hist (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (idx_q[AW-1:0]),
		.wdata (dir_q ? accm : x_q),
		.re    (cmd.rd_en),
		.raddr (AW'(idx_q - INDEX_W'(off))),
		.rdata (rdata)
	);

	assign vc1  = (vc_q == '0) ? INDEX_W'(1) : vc_q;
	logic last;
	assign last = (idx_q + INDEX_W'(1)) >= vc1 || idx_q == '1;
	assign nidx = last ? '0 : idx_q + INDEX_W'(1);

	logic [SAMPLE_W-1:0] sx;
	always_comb begin
		case (wc_q)
			2'd0:    sx = {{56{accm[7]}}, accm[7:0]};
			2'd1:    sx = {{48{accm[15]}}, accm[15:0]};
			2'd2:    sx = {{32{accm[31]}}, accm[31:0]};
			default: sx = accm;
		endcase
	end

	logic last_q;
	always_ff @(posedge clk) begin
		if (cmd.wr_en) last_q <= last;
		if (cmd.out_load) begin
			sample_out   <= sx;
			block_last   <= last_q;
			config_error <= largest >= SW'(WINDOW_DEPTH);
		end
	end

	ast_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en && last |=> idx_q == '0)
		else $error("index did not restart at block end");
	ast_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.wr_en && !cfg_we |=> $stable(idx_q))
		else $error("index moved without a write");
endmodule
`default_nettype wire

// ===== src/lorenzo_predictor_codec_top.sv =====
// Multi-dimensional Lorenzo predictor / reconstructor.
// Each sample steps through issue (2^d corners, d = dimensions used), drain, write, emit.
// A new sample is taken only once the last is done; corners are read one per cycle via
// the one read port of the history memory, and emit waits while a held result stalls.
// Reset: arst_n clears control and config registers; history memory is not cleared.
`default_nettype none
module lorenzo_predictor_codec_top
	import lpc_pkg::*;
#(
	parameter int unsigned WINDOW_DEPTH = 16384,
	parameter int unsigned MAX_DIMS     = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [63:0]  s_axis_tdata,   // sample_in
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [63:0]       m_axis_tdata,   // sample_out
	output logic              m_axis_tlast,   // block_last
	output logic              m_axis_tuser,   // config_error
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_idx,
	input  wire logic [47:0]  cfg_data
);
	lpc_cmd_t    cmd;
	lpc_status_t status;

	lpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	lpc_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .MAX_DIMS(MAX_DIMS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.sample_in    (s_axis_tdata),
		.cmd          (cmd),
		.status       (status),
		.sample_out   (m_axis_tdata),
		.block_last   (m_axis_tlast),
		.config_error (m_axis_tuser)
	);
endmodule
`default_nettype wire

// ===== verif/lorenzo_predictor_codec_top_tb.sv =====
`default_nettype none
module lorenzo_predictor_codec_top_tb;
	import lpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 16384;
	localparam int unsigned DRAIN = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [47:0] cfg_data = '0;

	lorenzo_predictor_codec_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	typedef struct {
		logic [63:0] sample;
		logic        last;
		logic        err;
	} lpc_result_t;

	lpc_result_t result_q[$];

	// predictor copy of the block's state and registers
	logic [63:0] hist [DEPTH];
	logic [47:0] next_idx;
	logic        m_dir;
	logic [1:0]  m_width;
	logic [2:0]  m_dims;
	logic [14:0] m_ext [3];
	logic [47:0] m_vcount;

	int unsigned n_sent = 0, n_checked = 0, n_errors = 0, n_last = 0, n_cfgerr = 0;
	bit quiet = 0;
	bit hold_sink = 0;
	int unsigned sink_wait = 0;

	task automatic report(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		n_errors++;
	endtask

	function automatic logic [63:0] one_if_zero(input logic [63:0] v);
		return (v == 0) ? 64'd1 : v;
	endfunction

	function automatic void lorenzo_predict(input logic [63:0] din);
		logic [63:0] stride [4];
		logic [63:0] largest, mask, x, acc, off, h, vc, ix;
		int unsigned d, wb, j, k;
		logic [3:0] jb;
		lpc_result_t r;
		d = (m_dims > 4) ? 4 : m_dims;
		wb = 8 << m_width;
		mask = (wb >= 64) ? '1 : ((64'd1 << wb) - 1);
		ix = {16'd0, next_idx};
		x = din & mask;
		vc = one_if_zero({16'd0, m_vcount});
		stride[0] = 1;
		stride[1] = one_if_zero({49'd0, m_ext[0]});
		stride[2] = stride[1] * one_if_zero({49'd0, m_ext[1]});
		stride[3] = stride[2] * one_if_zero({49'd0, m_ext[2]});
		largest = 0;
		for (k = 0; k < d; k++) largest += stride[k];
		r.err = (largest >= DEPTH);
		acc = m_dir ? x : 64'd0;
		for (j = m_dir ? 1 : 0; j < (1 << d); j++) begin
			jb = j[3:0];
			off = 0;
			for (k = 0; k < d; k++)
				if (jb[k]) off += stride[k];
			if (off > ix || off >= DEPTH) continue;
			h = (off == 0) ? x : hist[(ix - off) % DEPTH];
			if (!m_dir) acc = (^jb) ? acc - h : acc + h;
			else acc = (^jb) ? acc + h : acc - h;
		end
		acc &= mask;
		hist[ix % DEPTH] = m_dir ? acc : x;
		if (wb < 64 && acc[wb-1]) acc |= ~mask;
		r.last = (ix + 1) >= vc;
		next_idx = r.last ? 48'd0 : next_idx + 48'd1;
		r.sample = acc;
		result_q.push_back(r);
	endfunction

	task automatic write_reg(input lpc_reg_t r, input logic [47:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (r)
			REG_DIRECTION:    m_dir = v[0];
			REG_WIDTH_CODE:   m_width = v[1:0];
			REG_DIM_COUNT:    m_dims = v[2:0];
			REG_EXTENT_INNER: m_ext[0] = v[14:0];
			REG_EXTENT_2ND:   m_ext[1] = v[14:0];
			REG_EXTENT_3RD:   m_ext[2] = v[14:0];
			REG_VALUE_COUNT:  m_vcount = v;
			default: ;
		endcase
	endtask

	task automatic set_all(input logic d, input logic [1:0] w, input logic [2:0] n,
			input logic [14:0] e0, input logic [14:0] e1, input logic [14:0] e2,
			input logic [47:0] vc);
		write_reg(REG_DIRECTION, {47'd0, d});
		write_reg(REG_WIDTH_CODE, {46'd0, w});
		write_reg(REG_DIM_COUNT, {45'd0, n});
		write_reg(REG_EXTENT_INNER, {33'd0, e0});
		write_reg(REG_EXTENT_2ND, {33'd0, e1});
		write_reg(REG_EXTENT_3RD, {33'd0, e2});
		write_reg(REG_VALUE_COUNT, vc);
	endtask

	task automatic send_sample(input logic [63:0] v);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		do @(posedge clk); while (!s_axis_tready);
		lorenzo_predict(v);
		n_sent++;
	endtask

	// stop offering, drain, then let the pipeline go quiet before touching registers
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	always @(posedge clk) begin
		lpc_result_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			n_checked++;
			if (m_axis_tlast) n_last++;
			if (m_axis_tuser) n_cfgerr++;
			if (result_q.size() == 0) begin
				report("result transfer with nothing expected");
			end else begin
				e = result_q.pop_front();
				if (m_axis_tdata !== e.sample)
					report($sformatf("sample_out %h, want %h", m_axis_tdata, e.sample));
				if (m_axis_tlast !== e.last)
					report($sformatf("block_last %b, want %b", m_axis_tlast, e.last));
				if (m_axis_tuser !== e.err)
					report($sformatf("config_error %b, want %b", m_axis_tuser, e.err));
			end
			sink_wait = quiet ? 0 : $urandom_range(0, 15);
		end
		if (hold_sink) begin
			m_axis_tready <= 1'b0;
		end else if (sink_wait > 0) begin
			sink_wait--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic test_directed();
		set_all(1'b0, 2'd3, 3'd1, 15'd1, 15'd1, 15'd1, 48'd4);
		send_sample(64'h8000_0000_0000_0000);
		send_sample(64'h7FFF_FFFF_FFFF_FFFF);
		send_sample(64'd0);
		send_sample('1);
		settle();
		// 8-bit wrap and sign extension, reverse, two dimensions
		set_all(1'b1, 2'd0, 3'd2, 15'd2, 15'd1, 15'd1, 48'd6);
		send_sample(64'h0000_0000_0000_007F);
		send_sample(64'hFFFF_FFFF_FFFF_FF80);
		send_sample(64'h1234_5678_9ABC_DEF0);
		send_sample(64'h0000_0000_0000_00FF);
		send_sample(64'h01);
		send_sample(64'h80);
		settle();
		// no dimensions: output is the input sign-extended from 16 bits; zero extents and zero count
		set_all(1'b0, 2'd1, 3'd0, 15'd0, 15'd0, 15'd0, 48'd0);
		send_sample(64'h0000_0000_0000_8001);
		send_sample(64'h0000_0000_0000_7FFF);
		settle();
		// dimension count above the maximum, 32-bit
		set_all(1'b0, 2'd2, 3'd7, 15'd2, 15'd2, 15'd2, 48'hFFFF_FFFF_FFFF);
		repeat (3) send_sample(rand64());
		settle();
		// offset past the window: error flag, corner left out
		set_all(1'b0, 2'd3, 3'd2, 15'd16384, 15'd1, 15'd1, 48'd3);
		send_sample(rand64());
		send_sample(rand64());
		settle();
		write_reg(REG_EXTENT_INNER, 48'h7FFF);
		send_sample(rand64());
		settle();
		// count lowered mid-block: next sample ends it
		set_all(1'b0, 2'd3, 3'd1, 15'd1, 15'd1, 15'd1, 48'd10);
		repeat (3) send_sample(rand64());
		settle();
		write_reg(REG_VALUE_COUNT, 48'd2);
		repeat (2) send_sample(rand64());
		settle();
	endtask

	task automatic test_random();
		int unsigned ph, i, n;
		logic [14:0] e [3];
		logic [47:0] vc;
		for (ph = 0; ph < 20; ph++) begin
			quiet = (ph % 5 == 3);
			for (i = 0; i < 3; i++)
				e[i] = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom_range(1, 5));
			case ($urandom_range(0, 5))
				0: vc = 48'd0;
				1: vc = 48'hFFFF_FFFF_FFFF;
				2: vc = 48'($urandom_range(1, 8));
				default: vc = 48'($urandom_range(20, 150));
			endcase
			set_all(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
				3'($urandom_range(0, 4)), e[0], e[1], e[2], vc);
			n = $urandom_range(80, 105);
			for (i = 0; i < n; i++) begin
				// mostly small magnitudes so the sums stay meaningful, some full-range
				if ($urandom_range(0, 3) == 0) send_sample(rand64());
				else send_sample(64'($signed($urandom_range(0, 64)) - 32));
			end
			settle();
		end
		quiet = 0;
	endtask

	task automatic test_backpressure();
		set_all(1'b0, 2'd1, 3'd2, 15'd3, 15'd1, 15'd1, 48'd12);
		hold_sink = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_sink = 0;
			end
		join_none
		repeat (24) send_sample(rand64());
		settle();
	endtask

	initial begin
		next_idx = '0;
		m_dir = 0; m_width = 0; m_dims = 3'd1;
		m_ext[0] = 15'd1; m_ext[1] = 15'd1; m_ext[2] = 15'd1;
		m_vcount = 48'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		$display("Covered %0d samples in both directions, all widths and dimension counts,",
			n_sent);
		$display("%0d results checked, %0d block ends, %0d with config error flagged",
			n_checked, n_last, n_cfgerr);
		if (n_errors == 0 && result_q.size() == 0) begin
			$display("lorenzo_predictor_codec_top_tb: clean");
		end else begin
			$display("lorenzo_predictor_codec_top_tb: errors");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout waiting for transfers");
		$display("lorenzo_predictor_codec_top_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
